FILE: sv/lph_pkg.sv
// Shared types, codes and sizes for the linear probing hash table.
`default_nettype none
package lph_pkg;
    localparam int TableSize = 1021;

    typedef enum logic [2:0] {
        FN_INSERT = 3'd0,
        FN_GET    = 3'd1,
        FN_DELETE = 3'd2,
        FN_MIN    = 3'd3,
        FN_NEXT   = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        FL_EMPTY   = 2'd0,
        FL_FULL    = 2'd1,
        FL_DELETED = 2'd2
    } t_flag;

    typedef enum logic [1:0] {
        STS_MISS      = 2'd0,
        STS_DONE      = 2'd1,
        STS_OVERWRITE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_PROBE,
        ST_CHECK,
        ST_SCAN,
        ST_SCAN_LAST,
        ST_DONE
    } t_state;
endpackage
`default_nettype wire

FILE: sv/lph_if.sv
// Request and response channel interfaces.
`default_nettype none
interface lph_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [31:0] key;
    logic [63:0] data_in;
    modport source (output valid, func, key, data_in, input ready);
    modport sink (input valid, func, key, data_in, output ready);
endinterface

interface lph_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] key_out;
    logic [63:0] data_out;
    logic [9:0]  live_count;
    modport source (output valid, status, key_out, data_out, live_count, input ready);
    modport sink (input valid, status, key_out, data_out, live_count, output ready);
endinterface
`default_nettype wire

FILE: sv/lph_ram.sv
// Generic simple dual port RAM with registered read.
`default_nettype none
module lph_ram #(
    parameter int W = 32,
    parameter int D = 1021
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: sv/lph_hash.sv
// Home slot unit: (key * 17) mod table size by two reciprocal multiply passes.
`default_nettype none
module lph_hash #(
    parameter int TABLE_SIZE = lph_pkg::TableSize
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [31:0]                   i_key,
    output logic                               o_done,
    output logic [$clog2(TABLE_SIZE)-1:0]      o_slot
);
    localparam int SW = $clog2(TABLE_SIZE);
    localparam int SH = 32 + SW;
    localparam int QW = 65 - SH;
    localparam logic [63:0] RecipFull = (64'd1 << SH) / 64'(TABLE_SIZE);
    localparam logic [32:0] Recip = RecipFull[32:0];

    logic [31:0]   r_val, n_val;
    logic [QW-1:0] r_quo, n_quo;
    logic [SW-1:0] r_slot, n_slot;
    logic          r_busy, n_busy;
    logic          r_sub, n_sub;
    logic          r_pass, n_pass;
    logic          r_done, n_done;
    logic [64:0]   prod;
    logic [32:0]   quo_t, diff, rem;

    // quotient estimate is low by at most one, so one subtract corrects it
    assign prod  = 65'(r_val) * 65'(Recip);
    assign quo_t = 33'(r_quo) * 33'(TABLE_SIZE);
    assign diff  = {1'b0, r_val} - quo_t;
    assign rem   = (diff >= 33'(TABLE_SIZE)) ? diff - 33'(TABLE_SIZE) : diff;

    // reduce the key first, then reduce 17 times that remainder
    always_comb begin
        n_val  = r_val;
        n_quo  = r_quo;
        n_slot = r_slot;
        n_busy = r_busy;
        n_sub  = r_sub;
        n_pass = r_pass;
        n_done = 1'b0;
        if (i_start) begin
            n_val  = i_key;
            n_busy = 1'b1;
            n_sub  = 1'b0;
            n_pass = 1'b0;
        end else if (r_busy) begin
            if (!r_sub) begin
                n_quo = prod[64:SH];
                n_sub = 1'b1;
            end else begin
                n_sub = 1'b0;
                if (!r_pass) begin
                    n_val  = (rem[31:0] << 4) + rem[31:0];
                    n_pass = 1'b1;
                end else begin
                    n_slot = rem[SW-1:0];
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_sub  <= 1'b0;
            r_pass <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_sub  <= n_sub;
            r_pass <= n_pass;
        end
        r_val  <= n_val;
        r_quo  <= n_quo;
        r_slot <= n_slot;
    end

    assign o_done = r_done;
    assign o_slot = r_slot;
endmodule
`default_nettype wire

FILE: sv/linear_probe_hash_table.sv
// Linear probing key/data hash table: top level with sequencer.
// Usage:
//   i_req carries func, key and data_in; o_rsp returns status, key_out,
//   data_out and live_count, one response per request, in order.
//   Both channels move an item when valid and ready are high at a clock edge.
// Sequence:
//   insert, get, delete: accept, then the home slot by two reciprocal multiply
//   reduction passes, then per probed slot one RAM read and one check, then
//   the response register is loaded.
//   smallest key and next key: every slot in turn, one slot read per cycle
//   through the shared memory read port.
//   refused inserts and unused codes: accept, then straight to the response.
//   One item is in work at a time; the next request is taken as soon as the
//   sequencer is back in idle, even while the response register still waits.
// Reset:
//   the slot flag memory is swept to empty, one slot a cycle; requests are
//   not accepted during the sweep. Count resets to zero.
// Stall:
//   a held response stays in the output register; a finished item then
//   waits in the done state until the register frees.
`default_nettype none
module linear_probe_hash_table #(
    parameter int TABLE_SIZE = lph_pkg::TableSize
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lph_req_if.sink   i_req,
    lph_rsp_if.source o_rsp
);
    localparam int SW    = $clog2(TABLE_SIZE);
    localparam int CW    = $clog2(TABLE_SIZE + 1);
    localparam int Limit = TABLE_SIZE * 2 / 3;

    lph_pkg::t_state r_state, n_state;

    logic [2:0]    r_func, n_func;
    logic [31:0]   r_key, n_key;
    logic [63:0]   r_data, n_data;
    logic [SW-1:0] r_slot, n_slot;
    logic [SW-1:0] r_home, n_home;
    logic [SW-1:0] r_free, n_free;
    logic          r_have_free, n_have_free;
    logic [SW-1:0] r_idx, n_idx;
    logic          r_sv, n_sv;
    logic [CW-1:0] r_count, n_count;
    logic          r_have, n_have;
    logic [31:0]   r_best_key, n_best_key;
    logic [63:0]   r_best_data, n_best_data;
    logic [1:0]    r_res_status, n_res_status;
    logic [31:0]   r_res_key, n_res_key;
    logic [63:0]   r_res_data, n_res_data;
    logic          r_out_v, n_out_v;
    logic [1:0]    r_out_status, n_out_status;
    logic [31:0]   r_out_key, n_out_key;
    logic [63:0]   r_out_data, n_out_data;
    logic [9:0]    r_out_live, n_out_live;

    logic          hash_start, hash_done;
    logic [SW-1:0] hash_slot;
    logic [SW-1:0] raddr, waddr;
    logic          key_we, data_we, flag_we;
    logic [31:0]   wkey, rd_key;
    logic [63:0]   wdata, rd_data;
    logic [1:0]    wflag, rd_flag;
    logic          accept, refused, is_probe, is_scan;
    logic          hit, at_empty, nonfull, cand_v;
    logic [SW-1:0] cand, nxt;
    logic          scan_take;
    logic [CW+9:0] live_ext;

    assign accept   = i_req.valid && i_req.ready;
    assign refused  = (i_req.func == lph_pkg::FN_INSERT) && (r_count > CW'(Limit));
    assign is_probe = (i_req.func == lph_pkg::FN_INSERT) || (i_req.func == lph_pkg::FN_GET)
                      || (i_req.func == lph_pkg::FN_DELETE);
    assign is_scan  = (i_req.func == lph_pkg::FN_MIN) || (i_req.func == lph_pkg::FN_NEXT);
    assign hash_start = accept && is_probe && !refused;

    // probe check terms
    assign hit      = (rd_flag == lph_pkg::FL_FULL) && (rd_key == r_key);
    assign at_empty = (rd_flag == lph_pkg::FL_EMPTY);
    assign nonfull  = (rd_flag != lph_pkg::FL_FULL);
    assign cand_v   = r_have_free || nonfull;
    assign cand     = r_have_free ? r_free : r_slot;
    assign nxt      = (r_slot == SW'(TABLE_SIZE - 1)) ? '0 : r_slot + SW'(1);

    // scan candidate
    assign scan_take = (rd_flag == lph_pkg::FL_FULL)
                       && ((r_func != lph_pkg::FN_NEXT) || (rd_key > r_key))
                       && (!r_have || (rd_key < r_best_key));

    assign live_ext = {10'b0, r_count};

    lph_hash #(.TABLE_SIZE(TABLE_SIZE)) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (hash_start),
        .i_key   (i_req.key),
        .o_done  (hash_done),
        .o_slot  (hash_slot)
    );

    lph_ram #(.W(32), .D(TABLE_SIZE)) u_key_ram (
        .i_clk(i_clk), .i_we(key_we), .i_waddr(waddr), .i_wdata(wkey),
        .i_raddr(raddr), .o_rdata(rd_key)
    );
    lph_ram #(.W(64), .D(TABLE_SIZE)) u_data_ram (
        .i_clk(i_clk), .i_we(data_we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rd_data)
    );
    lph_ram #(.W(2), .D(TABLE_SIZE)) u_flag_ram (
        .i_clk(i_clk), .i_we(flag_we), .i_waddr(waddr), .i_wdata(wflag),
        .i_raddr(raddr), .o_rdata(rd_flag)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lph_pkg::ST_CLEAR: begin
                if (r_idx == SW'(TABLE_SIZE - 1)) n_state = lph_pkg::ST_IDLE;
            end
            lph_pkg::ST_IDLE: begin
                if (accept) begin
                    if (hash_start) n_state = lph_pkg::ST_HASH;
                    else if (is_scan) n_state = lph_pkg::ST_SCAN;
                    else n_state = lph_pkg::ST_DONE;
                end
            end
            lph_pkg::ST_HASH: begin
                if (hash_done) n_state = lph_pkg::ST_PROBE;
            end
            lph_pkg::ST_PROBE: n_state = lph_pkg::ST_CHECK;
            lph_pkg::ST_CHECK: begin
                if (hit || at_empty || (nxt == r_home)) n_state = lph_pkg::ST_DONE;
                else n_state = lph_pkg::ST_PROBE;
            end
            lph_pkg::ST_SCAN: begin
                if (r_idx == SW'(TABLE_SIZE - 1)) n_state = lph_pkg::ST_SCAN_LAST;
            end
            lph_pkg::ST_SCAN_LAST: n_state = lph_pkg::ST_DONE;
            lph_pkg::ST_DONE: begin
                if (!r_out_v || o_rsp.ready) n_state = lph_pkg::ST_IDLE;
            end
            default: n_state = lph_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_func       = r_func;
        n_key        = r_key;
        n_data       = r_data;
        n_slot       = r_slot;
        n_home       = r_home;
        n_free       = r_free;
        n_have_free  = r_have_free;
        n_idx        = r_idx;
        n_sv         = 1'b0;
        n_count      = r_count;
        n_have       = r_have;
        n_best_key   = r_best_key;
        n_best_data  = r_best_data;
        n_res_status = r_res_status;
        n_res_key    = r_res_key;
        n_res_data   = r_res_data;
        n_out_v      = r_out_v && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_key    = r_out_key;
        n_out_data   = r_out_data;
        n_out_live   = r_out_live;
        raddr        = r_slot;
        waddr        = r_slot;
        key_we       = 1'b0;
        data_we      = 1'b0;
        flag_we      = 1'b0;
        wkey         = r_key;
        wdata        = r_data;
        wflag        = lph_pkg::FL_EMPTY;
        case (r_state)
            lph_pkg::ST_CLEAR: begin
                // sweep flags to empty
                waddr   = r_idx;
                flag_we = 1'b1;
                n_idx   = r_idx + SW'(1);
            end
            lph_pkg::ST_IDLE: begin
                if (accept) begin
                    n_func       = i_req.func;
                    n_key        = i_req.key;
                    n_data       = i_req.data_in;
                    n_idx        = '0;
                    n_have       = 1'b0;
                    n_have_free  = 1'b0;
                    n_res_status = lph_pkg::STS_MISS;
                    n_res_key    = '0;
                    n_res_data   = '0;
                end
            end
            lph_pkg::ST_HASH: begin
                n_slot = hash_slot;
                n_home = hash_slot;
            end
            lph_pkg::ST_PROBE: begin
                raddr = r_slot;
            end
            lph_pkg::ST_CHECK: begin
                // remember first non-full slot for insert
                if (!r_have_free && nonfull) begin
                    n_have_free = 1'b1;
                    n_free      = r_slot;
                end
                if (hit) begin
                    case (r_func)
                        lph_pkg::FN_INSERT: begin
                            data_we      = 1'b1;
                            n_res_status = lph_pkg::STS_OVERWRITE;
                        end
                        lph_pkg::FN_GET: begin
                            n_res_status = lph_pkg::STS_DONE;
                            n_res_key    = rd_key;
                            n_res_data   = rd_data;
                        end
                        lph_pkg::FN_DELETE: begin
                            n_res_status = lph_pkg::STS_DONE;
                            n_res_key    = rd_key;
                            n_res_data   = rd_data;
                            flag_we      = 1'b1;
                            wflag        = lph_pkg::FL_DELETED;
                            if (r_count != '0) n_count = r_count - CW'(1);
                        end
                        default: ;
                    endcase
                end else if (at_empty || (nxt == r_home)) begin
                    // miss: an insert places its key in the first free slot, if any
                    if ((r_func == lph_pkg::FN_INSERT) && cand_v) begin
                        waddr        = cand;
                        key_we       = 1'b1;
                        data_we      = 1'b1;
                        flag_we      = 1'b1;
                        wflag        = lph_pkg::FL_FULL;
                        n_count      = r_count + CW'(1);
                        n_res_status = lph_pkg::STS_DONE;
                    end
                end else begin
                    n_slot = nxt;
                end
            end
            lph_pkg::ST_SCAN, lph_pkg::ST_SCAN_LAST: begin
                // stream slots and keep the smallest qualifying key
                raddr = r_idx;
                if (r_state == lph_pkg::ST_SCAN) begin
                    n_sv  = 1'b1;
                    n_idx = r_idx + SW'(1);
                end
                if ((r_sv || r_state == lph_pkg::ST_SCAN_LAST) && scan_take) begin
                    n_have      = 1'b1;
                    n_best_key  = rd_key;
                    n_best_data = rd_data;
                end
            end
            lph_pkg::ST_DONE: begin
                if (!r_out_v || o_rsp.ready) begin
                    n_out_v    = 1'b1;
                    n_out_live = live_ext[9:0];
                    if ((r_func == lph_pkg::FN_MIN) || (r_func == lph_pkg::FN_NEXT)) begin
                        n_out_status = r_have ? lph_pkg::STS_DONE : lph_pkg::STS_MISS;
                        n_out_key    = r_have ? r_best_key : '0;
                        n_out_data   = r_have ? r_best_data : '0;
                    end else begin
                        n_out_status = r_res_status;
                        n_out_key    = r_res_key;
                        n_out_data   = r_res_data;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lph_pkg::ST_CLEAR;
            r_idx   <= '0;
            r_sv    <= 1'b0;
            r_count <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_sv    <= n_sv;
            r_count <= n_count;
            r_out_v <= n_out_v;
        end
        r_func       <= n_func;
        r_key        <= n_key;
        r_data       <= n_data;
        r_slot       <= n_slot;
        r_home       <= n_home;
        r_free       <= n_free;
        r_have_free  <= n_have_free;
        r_have       <= n_have;
        r_best_key   <= n_best_key;
        r_best_data  <= n_best_data;
        r_res_status <= n_res_status;
        r_res_key    <= n_res_key;
        r_res_data   <= n_res_data;
        r_out_status <= n_out_status;
        r_out_key    <= n_out_key;
        r_out_data   <= n_out_data;
        r_out_live   <= n_out_live;
    end

    assign i_req.ready      = (r_state == lph_pkg::ST_IDLE);
    assign o_rsp.valid      = r_out_v;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.key_out    = r_out_key;
    assign o_rsp.data_out   = r_out_data;
    assign o_rsp.live_count = r_out_live;
endmodule
`default_nettype wire
